[rtl/bfst_pkg.sv]
// Shared types, character codes and helpers for the brace format string tokenizer.
// No dependencies; every other file in rtl/ imports this package.
package bfst_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_OPEN  = 2'd1,
        PH_FIELD = 2'd2,
        PH_CLOSE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_TEXT = 3'd1,
        EV_POS  = 3'd2,
        EV_NAME = 3'd3,
        EV_END  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_UTF8   = 3'd1,
        ERR_NESTED = 3'd2,
        ERR_OPEN   = 3'd3,
        ERR_NAME   = 3'd4,
        ERR_CLOSE  = 3'd5
    } err_t;

    // Allowed range of the first continuation byte after a lead byte.
    typedef enum logic [2:0] {
        RNG_80_BF = 3'd0,
        RNG_A0_BF = 3'd1,
        RNG_80_9F = 3'd2,
        RNG_90_BF = 3'd3,
        RNG_80_8F = 3'd4
    } range_t;

    typedef struct packed {
        event_t ev;
        err_t   perr;
        logic   named;
    } parse_res_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || (b == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39);
    endfunction

endpackage

[rtl/bfst_utf8.sv]
// UTF-8 well-formedness checker: one byte per enabled cycle, state cleared after the last byte.
// Depends on bfst_pkg.
module bfst_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       fail
);
    import bfst_pkg::*;

    logic [1:0] owed_reg, owed_next;
    range_t     range_reg, range_next;
    logic       failed_reg, failed_next;
    logic [7:0] lo, hi;

    always_comb begin
        owed_next   = owed_reg;
        range_next  = range_reg;
        failed_next = failed_reg;
        lo          = 8'h80;
        hi          = 8'hBF;
        case (range_reg)
            RNG_A0_BF: lo = 8'hA0;
            RNG_80_9F: hi = 8'h9F;
            RNG_90_BF: lo = 8'h90;
            RNG_80_8F: hi = 8'h8F;
            default: ;
        endcase
        if (!failed_reg) begin
            if (owed_reg == 2'd0) begin
                if (data_byte < 8'h80) begin
                    owed_next = 2'd0;
                end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
                    owed_next  = 2'd1;
                    range_next = RNG_80_BF;
                end else if (data_byte == 8'hE0) begin
                    owed_next  = 2'd2;
                    range_next = RNG_A0_BF;
                end else if (data_byte == 8'hED) begin
                    owed_next  = 2'd2;
                    range_next = RNG_80_9F;
                end else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) begin
                    owed_next  = 2'd2;
                    range_next = RNG_80_BF;
                end else if (data_byte == 8'hF0) begin
                    owed_next  = 2'd3;
                    range_next = RNG_90_BF;
                end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
                    owed_next  = 2'd3;
                    range_next = RNG_80_BF;
                end else if (data_byte == 8'hF4) begin
                    owed_next  = 2'd3;
                    range_next = RNG_80_8F;
                end else begin
                    failed_next = 1'b1;
                    owed_next   = 2'd0;
                    range_next  = RNG_80_BF;
                end
            end else if (data_byte < lo || data_byte > hi) begin
                failed_next = 1'b1;
                owed_next   = 2'd0;
                range_next  = RNG_80_BF;
            end else begin
                owed_next  = owed_reg - 2'd1;
                range_next = RNG_80_BF;
            end
        end
        // A sequence cut short by the end of the string is malformed.
        if (last && owed_next != 2'd0) begin
            failed_next = 1'b1;
        end
    end

    assign fail = failed_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (en && last)) begin
            owed_reg   <= 2'd0;
            range_reg  <= RNG_80_BF;
            failed_reg <= 1'b0;
        end else if (en) begin
            owed_reg   <= owed_next;
            range_reg  <= range_next;
            failed_reg <= failed_next;
        end
    end

endmodule

[rtl/bfst_parse.sv]
// Brace parser: phase tracking, field name checks and first parse error, one byte per enabled cycle.
// Depends on bfst_pkg.
module bfst_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [7:0]          data_byte,
    input  logic                last,
    output bfst_pkg::parse_res_t res
);
    import bfst_pkg::*;

    phase_t phase_reg, phase_next;
    logic   invalid_reg, invalid_next;
    err_t   perr_reg, perr_next;
    logic   named_reg, named_next;
    event_t ev;

    always_comb begin
        phase_next   = phase_reg;
        invalid_next = invalid_reg;
        perr_next    = perr_reg;
        named_next   = named_reg;
        ev           = EV_NONE;
        if (perr_reg == ERR_NONE) begin
            unique case (phase_reg)
                PH_OPEN: begin
                    if (data_byte == CH_OPEN) begin
                        phase_next = PH_TEXT;
                        ev         = EV_TEXT;
                    end else if (data_byte == CH_CLOSE) begin
                        phase_next = PH_TEXT;
                        ev         = EV_POS;
                    end else begin
                        phase_next   = PH_FIELD;
                        invalid_next = !is_letter(data_byte);
                        ev           = EV_NAME;
                    end
                end
                PH_FIELD: begin
                    if (data_byte == CH_OPEN) begin
                        perr_next = ERR_NESTED;
                    end else if (data_byte == CH_CLOSE) begin
                        // A bad name is only reported once the field closes.
                        if (invalid_reg) begin
                            perr_next = ERR_NAME;
                        end else begin
                            ev         = EV_END;
                            named_next = 1'b1;
                            phase_next = PH_TEXT;
                        end
                    end else begin
                        if (!is_letter(data_byte) && !is_digit(data_byte)) begin
                            invalid_next = 1'b1;
                        end
                        ev = EV_NAME;
                    end
                end
                PH_CLOSE: begin
                    if (data_byte == CH_CLOSE) begin
                        phase_next = PH_TEXT;
                        ev         = EV_TEXT;
                    end else begin
                        perr_next = ERR_CLOSE;
                    end
                end
                PH_TEXT: begin
                    if (data_byte == CH_OPEN) begin
                        phase_next = PH_OPEN;
                    end else if (data_byte == CH_CLOSE) begin
                        phase_next = PH_CLOSE;
                    end else begin
                        ev = EV_TEXT;
                    end
                end
            endcase
        end
        if (last && perr_next == ERR_NONE) begin
            if (phase_next == PH_OPEN || phase_next == PH_FIELD) begin
                perr_next = ERR_OPEN;
            end else if (phase_next == PH_CLOSE) begin
                perr_next = ERR_CLOSE;
            end
        end
    end

    assign res.ev    = ev;
    assign res.perr  = perr_next;
    assign res.named = named_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (en && last)) begin
            phase_reg   <= PH_TEXT;
            invalid_reg <= 1'b0;
            perr_reg    <= ERR_NONE;
            named_reg   <= 1'b0;
        end else if (en) begin
            phase_reg   <= phase_next;
            invalid_reg <= invalid_next;
            perr_reg    <= perr_next;
            named_reg   <= named_next;
        end
    end

endmodule

[rtl/brace_format_string_tokenizer.sv]
// Top level of the brace format string tokenizer: input register, parser, UTF-8 check, result register.
// Depends on bfst_pkg, bfst_utf8 and bfst_parse.
//
// Usage: the format string enters on the s_ channel one byte per request, s_tdata holding
// the byte and s_tlast marking the final byte of the string. Every input byte yields exactly
// one result request on the m_ channel: m_tuser carries the token event, m_tdata the token
// byte, error code and named-field flag, and m_tlast copies the input's last mark. The error
// code on the result with m_tlast set is the verdict for the whole string; a consumer drops
// all tokens of a string whose verdict is nonzero.
// Pipeline: a byte accepted on the s_ channel sits in the input register and moves into the
// result register, raising m_tvalid, once that register is empty or the receiver takes its
// current result. The parser and UTF-8 state update in a single pass.
// Throughput is one byte per cycle while the receiver does not stall.
// After the last byte of a string all parse and UTF-8 state returns to its reset values.
// Reset empties both registers and clears the parse state. When the receiver stalls, the
// result register holds, the input register fills and s_tready drops; nothing is lost.
module brace_format_string_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] token_byte, [10:8] error_code, [11] uses_named
    output logic [2:0]  m_tuser,   // [2:0] token_event
    output logic        m_tlast    // out_last
);
    import bfst_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       advance;

    logic       m_valid_reg;
    event_t     m_event_reg;
    logic [7:0] m_byte_reg;
    err_t       m_err_reg;
    logic       m_named_reg;
    logic       m_last_reg;

    logic       utf8_fail;
    parse_res_t pres;
    err_t       err_next;
    logic [7:0] byte_next;

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
    end

    bfst_utf8 u_utf8 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .data_byte (s1_byte_reg),
        .last      (s1_last_reg),
        .fail      (utf8_fail)
    );

    bfst_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .data_byte (s1_byte_reg),
        .last      (s1_last_reg),
        .res       (pres)
    );

    assign err_next  = utf8_fail ? ERR_UTF8 : pres.perr;
    assign byte_next = (pres.ev == EV_TEXT || pres.ev == EV_NAME) ? s1_byte_reg : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_event_reg <= pres.ev;
            m_byte_reg  <= byte_next;
            m_err_reg   <= err_next;
            m_named_reg <= pres.named;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_event_reg;
    assign m_tdata  = {4'd0, m_named_reg, m_err_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;

    // Tokens are only produced while no parse error is recorded. A field left open by the
    // final byte still streams that byte, and the same result carries the open brace error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_event_reg != EV_NONE |-> m_err_reg == ERR_NONE ||
            m_err_reg == ERR_UTF8 || (m_last_reg && m_err_reg == ERR_OPEN))
        else $error("token emitted after a parse error");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_event_reg != EV_TEXT && m_event_reg != EV_NAME |-> m_byte_reg == 8'd0)
        else $error("token byte set on an event without a byte");

    // A held input byte must stay until it moves into the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("input register lost a byte while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg)
        else $error("result dropped while the receiver stalled");

endmodule
